// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; they compile away for
// synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/bcte_pkg.sv
// ----------------------------------------------------------------------------
// bcte_pkg
// Shared types for the BCD civil time to epoch block: micro-op codes,
// operand selects, constant selects and the datapath control word.
// ----------------------------------------------------------------------------
package bcte_pkg;

    // Datapath operations; a step with OP_NOP may still carry a jump
    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,  // no datapath action
        OP_T_LD   = 3'd1,  // tmp  <= prod
        OP_T_ADD  = 3'd2,  // tmp  <= tmp + prod
        OP_T_SHR  = 3'd3,  // tmp  <= prod >> reciprocal shift
        OP_A_LD   = 3'd4,  // acc  <= tmp + prod
        OP_A_ADD  = 3'd5,  // acc  <= acc + prod
        OP_A_SUB  = 3'd6,  // acc  <= acc - prod
        OP_A_PROD = 3'd7   // acc  <= prod
    } t_op;

    // Multiplier operand select
    typedef enum logic [3:0] {
        SRC_ONE   = 4'd0,
        SRC_SEC   = 4'd1,
        SRC_MIN   = 4'd2,
        SRC_HR    = 4'd3,
        SRC_DAY   = 4'd4,
        SRC_MP    = 4'd5,
        SRC_YOE   = 4'd6,
        SRC_YQ4   = 4'd7,
        SRC_YQ100 = 4'd8,
        SRC_TMP   = 4'd9,
        SRC_ACC   = 4'd10
    } t_src;

    // Multiplier constant select
    typedef enum logic [3:0] {
        K_1      = 4'd0,
        K_2      = 4'd1,
        K_60     = 4'd2,
        K_153    = 4'd3,
        K_365    = 4'd4,
        K_3600   = 4'd5,
        K_RECIP5 = 4'd6,
        K_OFS_HI = 4'd7,
        K_OFS_LO = 4'd8,
        K_DAY    = 4'd9
    } t_kidx;

    // Jump conditions
    typedef enum logic [1:0] {
        JC_NONE   = 2'd0,
        JC_ALWAYS = 2'd1,
        JC_PREV   = 2'd2
    } t_jc;

    localparam int PcW = 4;

    typedef struct packed {
        t_op            op;
        t_src           src;
        t_kidx          kidx;
        t_jc            jc;
        logic [PcW-1:0] target;
        logic           last;
    } t_uword;

    // Control from sequencer to datapath
    typedef struct packed {
        logic  en;
        t_op   op;
        t_src  src;
        t_kidx kidx;
    } t_dp_ctl;

    // Decoded operands held for the duration of one item
    typedef struct packed {
        logic [7:0] sec;
        logic [7:0] min;
        logic [7:0] hr;
        logic [7:0] day;
        logic [7:0] mp;
        logic [8:0] yoe;
    } t_fields;

endpackage

// File: rtl/core/bcd_civil_time_to_epoch_uptime.sv
// ----------------------------------------------------------------------------
// bcd_civil_time_to_epoch_uptime
// Raw BCD clock bytes to epoch seconds since 1970-01-01 and uptime since a
// captured boot epoch, computed by a microcoded multiply-accumulate engine.
// ----------------------------------------------------------------------------
// Flow: the microprogram runs, taking a shorter path when the adjusted year falls
//   in the previous era, and the result is then loaded into the output register.
// Input: stalled from acceptance until the result is loaded; a finished item
//   waits in hold, with the input stalled, while the previous result beat is
//   still stalled.
// Reset: synchronous, active low; clears handshake state and the boot flag.
`include "assert_macros.svh"

module bcd_civil_time_to_epoch_uptime import bcte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_seconds_bcd,
    input  logic [7:0]  i_minutes_bcd,
    input  logic [7:0]  i_hours_bcd,
    input  logic [7:0]  i_day_bcd,
    input  logic [7:0]  i_month_bcd,
    input  logic [7:0]  i_year_bcd,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_epoch_seconds,
    output logic [31:0] o_uptime_seconds
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    function automatic logic [7:0] bcd_dec(input logic [7:0] b);
        return {4'd0, b[3:0]} + ({4'd0, b[7:4]} << 3) + ({4'd0, b[7:4]} << 1);
    endfunction

    t_state      r_state, n_state;
    t_fields     r_fld, n_fld;
    logic        r_prev, n_prev;
    logic        r_opcode;
    logic        r_out_valid;
    logic [31:0] r_epoch, r_uptime;
    logic [31:0] r_boot;
    logic        r_boot_valid;

    logic        w_accept, w_fin, w_load, w_capture, w_done;
    logic [7:0]  w_mon, w_yr;
    logic        w_le2;
    logic [31:0] w_acc;
    t_dp_ctl     w_ctl;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Months up to February count from March of the year before
    assign w_mon = bcd_dec(i_month_bcd);
    assign w_yr  = bcd_dec(i_year_bcd);
    assign w_le2 = (w_mon <= 8'd2);

    always_comb begin
        n_fld.sec = bcd_dec(i_seconds_bcd);
        n_fld.min = bcd_dec(i_minutes_bcd);
        n_fld.hr  = bcd_dec(i_hours_bcd);
        n_fld.day = bcd_dec(i_day_bcd);
        n_fld.mp  = w_le2 ? w_mon + 8'd9 : w_mon - 8'd3;
        n_prev    = w_le2 && (w_yr == 8'd0);
        // Year 1999 sits at the end of the previous era
        n_fld.yoe = n_prev ? 9'd399 : {1'b0, w_yr} - {8'd0, w_le2};
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fld    <= n_fld;
            r_prev   <= n_prev;
            r_opcode <= i_opcode;
        end
    end

    bcte_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_prev_era (r_prev),
        .o_ctl      (w_ctl),
        .o_done     (w_done)
    );

    bcte_dp u_dp (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_fld (r_fld),
        .o_acc (w_acc)
    );

    assign w_fin     = ((r_state == S_RUN) && w_done) || (r_state == S_HOLD);
    assign w_load    = w_fin && (!r_out_valid || !i_out_stall);
    assign w_capture = r_opcode || !r_boot_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_RUN;
            S_RUN:   if (w_done) n_state = w_load ? S_IDLE : S_HOLD;
            S_HOLD:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_boot_valid <= 1'b0;
            r_boot       <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_load && w_capture) begin
                r_boot_valid <= 1'b1;
                r_boot       <= w_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_epoch  <= w_acc;
            r_uptime <= w_capture ? '0 : w_acc - r_boot;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_epoch_seconds  = r_epoch;
    assign o_uptime_seconds = r_uptime;

    `ASSERT_IMPL(a_done_in_run, i_clk, i_rst_n, w_done, r_state == S_RUN, "done outside run")
    `ASSERT_NEXT(a_boot_sticky, i_clk, i_rst_n, r_boot_valid, r_boot_valid, "boot flag lost")
    `ASSERT_NEXT(a_capture_zero, i_clk, i_rst_n, w_load && w_capture, r_uptime == '0, "uptime set")

endmodule

// File: rtl/core/bcte_seq.sv
// ----------------------------------------------------------------------------
// bcte_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcte_seq import bcte_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_prev_era,
    output t_dp_ctl o_ctl,
    output logic    o_done
);

    // Days since epoch, then seconds. Era offsets are era*146097 - 719468.
    function automatic t_uword rom(input logic [PcW-1:0] pc);
        t_uword w;
        w = '{op: OP_NOP, src: SRC_ONE, kidx: K_1, jc: JC_NONE, target: '0, last: 1'b0};
        unique case (pc)
            4'd0:  begin w.op = OP_T_LD;   w.src = SRC_MP;    w.kidx = K_153;    end
            4'd1:  begin w.op = OP_T_ADD;  w.src = SRC_ONE;   w.kidx = K_2;      end
            4'd2:  begin w.op = OP_T_SHR;  w.src = SRC_TMP;   w.kidx = K_RECIP5; end
            4'd3:  begin w.op = OP_A_LD;   w.src = SRC_DAY;   w.kidx = K_1;      end
            4'd4:  begin w.op = OP_A_SUB;  w.src = SRC_ONE;   w.kidx = K_1;      end
            4'd5:  begin w.op = OP_A_ADD;  w.src = SRC_YOE;   w.kidx = K_365;    end
            4'd6:  begin w.op = OP_A_ADD;  w.src = SRC_YQ4;   w.kidx = K_1;      end
            4'd7:  begin w.op = OP_A_SUB;  w.src = SRC_YQ100; w.kidx = K_1;      end
            4'd8:  begin w.jc = JC_PREV;   w.target = 4'd11;                     end
            4'd9:  begin w.op = OP_A_ADD;  w.src = SRC_ONE;   w.kidx = K_OFS_HI; end
            4'd10: begin w.jc = JC_ALWAYS; w.target = 4'd12;                     end
            4'd11: begin w.op = OP_A_SUB;  w.src = SRC_ONE;   w.kidx = K_OFS_LO; end
            4'd12: begin w.op = OP_A_PROD; w.src = SRC_ACC;   w.kidx = K_DAY;    end
            4'd13: begin w.op = OP_A_ADD;  w.src = SRC_HR;    w.kidx = K_3600;   end
            4'd14: begin w.op = OP_A_ADD;  w.src = SRC_MIN;   w.kidx = K_60;     end
            4'd15: begin
                w.op = OP_A_ADD; w.src = SRC_SEC; w.kidx = K_1; w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

    logic [PcW-1:0] r_pc, n_pc;
    logic           r_run, n_run;
    logic           r_done, n_done;
    t_uword         w_word;
    logic           w_take;

    assign w_word = rom(r_pc);

    always_comb begin
        priority case (w_word.jc)
            JC_ALWAYS: w_take = 1'b1;
            JC_PREV:   w_take = i_prev_era;
            default:   w_take = 1'b0;
        endcase
    end

    always_comb begin
        n_pc   = r_pc;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_start) begin
            n_pc  = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            n_pc = w_take ? w_word.target : r_pc + 1'b1;
            if (w_word.last) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    assign o_ctl  = '{en: r_run, op: w_word.op, src: w_word.src, kidx: w_word.kidx};
    assign o_done = r_done;

    `ASSERT_IMPL(a_done_stops, i_clk, i_rst_n, r_done, !r_run, "sequencer still running at done")
    `ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, i_start, !r_run, "start while program running")

endmodule

// File: rtl/core/bcte_dp.sv
// ----------------------------------------------------------------------------
// bcte_dp
// Shared multiply-accumulate datapath: one 32x18 constant multiplier feeding
// a temporary and an accumulator register.
// ----------------------------------------------------------------------------
module bcte_dp import bcte_pkg::*; (
    input  logic        i_clk,
    input  t_dp_ctl     i_ctl,
    input  t_fields     i_fld,
    output logic [31:0] o_acc
);

    localparam int KW       = 18;
    localparam int DivShift = 18;   // x/5 == (x*52429) >> 18 for x below 2^16

    function automatic logic [KW-1:0] kval(input t_kidx k);
        logic [KW-1:0] v;
        unique case (k)
            K_1:      v = 18'd1;
            K_2:      v = 18'd2;
            K_60:     v = 18'd60;
            K_153:    v = 18'd153;
            K_365:    v = 18'd365;
            K_3600:   v = 18'd3600;
            K_RECIP5: v = 18'd52429;
            K_OFS_HI: v = 18'd11017;
            K_OFS_LO: v = 18'd135080;
            K_DAY:    v = 18'd86400;
            default:  v = '0;
        endcase
        return v;
    endfunction

    logic [31:0] r_acc;
    logic [15:0] r_tmp;
    logic [31:0] w_mul_a;
    logic [31:0] w_prod;
    logic [6:0]  w_yq4;
    logic [1:0]  w_yq100;

    assign w_yq4 = i_fld.yoe[8:2];

    // Year of era stays below 400
    always_comb begin
        priority if (i_fld.yoe >= 9'd300) w_yq100 = 2'd3;
        else if (i_fld.yoe >= 9'd200)     w_yq100 = 2'd2;
        else if (i_fld.yoe >= 9'd100)     w_yq100 = 2'd1;
        else                              w_yq100 = 2'd0;
    end

    always_comb begin
        unique case (i_ctl.src)
            SRC_ONE:   w_mul_a = 32'd1;
            SRC_SEC:   w_mul_a = {24'd0, i_fld.sec};
            SRC_MIN:   w_mul_a = {24'd0, i_fld.min};
            SRC_HR:    w_mul_a = {24'd0, i_fld.hr};
            SRC_DAY:   w_mul_a = {24'd0, i_fld.day};
            SRC_MP:    w_mul_a = {24'd0, i_fld.mp};
            SRC_YOE:   w_mul_a = {23'd0, i_fld.yoe};
            SRC_YQ4:   w_mul_a = {25'd0, w_yq4};
            SRC_YQ100: w_mul_a = {30'd0, w_yq100};
            SRC_TMP:   w_mul_a = {16'd0, r_tmp};
            SRC_ACC:   w_mul_a = r_acc;
            default:   w_mul_a = '0;
        endcase
    end

    // Low 32 bits only: the accumulator wraps modulo 2^32 and the temporary keeps 16 bits
    assign w_prod = w_mul_a * {{(32-KW){1'b0}}, kval(i_ctl.kidx)};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            unique case (i_ctl.op)
                OP_NOP:    ;
                OP_T_LD:   r_tmp <= w_prod[15:0];
                OP_T_ADD:  r_tmp <= r_tmp + w_prod[15:0];
                OP_T_SHR:  r_tmp <= 16'(w_prod >> DivShift);
                OP_A_LD:   r_acc <= {16'd0, r_tmp} + w_prod;
                OP_A_ADD:  r_acc <= r_acc + w_prod;
                OP_A_SUB:  r_acc <= r_acc - w_prod;
                OP_A_PROD: r_acc <= w_prod;
            endcase
        end
    end

    assign o_acc = r_acc;

endmodule

// File: tb/sv/tb_bcd_civil_time_to_epoch_uptime.sv
// ----------------------------------------------------------------------------
// tb_bcd_civil_time_to_epoch_uptime
// Drives raw BCD clock readings into the block and checks every epoch and
// uptime beat against an in-bench calendar predictor that tracks the boot
// epoch, over phases of free flow, sparse input, heavy backpressure and both.
// ----------------------------------------------------------------------------
module tb_bcd_civil_time_to_epoch_uptime;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit        OPC_QUERY     = 1'b0;
    localparam bit        OPC_SET_BOOT  = 1'b1;
    localparam bit [31:0] YEAR_BASE     = 32'd2000;
    localparam bit [31:0] DAYS_PER_ERA  = 32'd146097;
    localparam bit [31:0] EPOCH_OFFSET  = 32'd719468;
    localparam bit [31:0] SECS_PER_DAY  = 32'd86400;
    localparam bit [31:0] SECS_PER_HOUR = 32'd3600;
    localparam int        RANDOM_PER_PHASE = 275;
    localparam int        STALL_LIMIT      = 4000;
    localparam int        SETTLE_CYCLES    = 40;

    typedef struct packed {
        bit       drain_first;
        bit       opcode;
        bit [7:0] sec;
        bit [7:0] min;
        bit [7:0] hr;
        bit [7:0] day;
        bit [7:0] mon;
        bit [7:0] yr;
    } clock_reading_t;

    typedef struct packed {
        bit [31:0] epoch;
        bit [31:0] uptime;
    } uptime_result_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic        i_opcode      = 1'b0;
    logic [7:0]  i_seconds_bcd = '0;
    logic [7:0]  i_minutes_bcd = '0;
    logic [7:0]  i_hours_bcd   = '0;
    logic [7:0]  i_day_bcd     = '0;
    logic [7:0]  i_month_bcd   = '0;
    logic [7:0]  i_year_bcd    = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [31:0] o_epoch_seconds;
    logic [31:0] o_uptime_seconds;

    clock_reading_t readings_q[$];
    uptime_result_t expected_q[$];

    bit [31:0] boot_mark;
    bit        boot_set;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        fail_count;
    int        quiet_cycles;
    bit        in_took;

    bcd_civil_time_to_epoch_uptime u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_seconds_bcd    (i_seconds_bcd),
        .i_minutes_bcd    (i_minutes_bcd),
        .i_hours_bcd      (i_hours_bcd),
        .i_day_bcd        (i_day_bcd),
        .i_month_bcd      (i_month_bcd),
        .i_year_bcd       (i_year_bcd),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_epoch_seconds  (o_epoch_seconds),
        .o_uptime_seconds (o_uptime_seconds)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit [31:0] bcd_value(bit [7:0] b);
        return 32'(b[3:0]) + 32'(b[7:4]) * 32'd10;
    endfunction

    function automatic bit [7:0] to_bcd(int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // Days since 1970-01-01 by era and day of era; everything wraps at 32 bits
    function automatic bit [31:0] days_since_1970(bit [31:0] year, bit [31:0] month,
                                                  bit [31:0] day);
        bit [31:0] y;
        bit [31:0] era;
        bit [31:0] yoe;
        bit [31:0] mp;
        bit [31:0] doy;
        bit [31:0] doe;
        y   = (month <= 32'd2) ? year - 32'd1 : year;
        era = y / 32'd400;
        yoe = y - era * 32'd400;
        mp  = (month > 32'd2) ? month - 32'd3 : month + 32'd9;
        doy = (32'd153 * mp + 32'd2) / 32'd5 + day - 32'd1;
        doe = yoe * 32'd365 + yoe / 32'd4 - yoe / 32'd100 + doy;
        return era * DAYS_PER_ERA + doe - EPOCH_OFFSET;
    endfunction

    function automatic uptime_result_t predict_uptime(clock_reading_t r);
        uptime_result_t res;
        bit [31:0]      days;
        days = days_since_1970(YEAR_BASE + bcd_value(r.yr), bcd_value(r.mon),
                               bcd_value(r.day));
        res.epoch = days * SECS_PER_DAY + bcd_value(r.hr) * SECS_PER_HOUR
                    + bcd_value(r.min) * 32'd60 + bcd_value(r.sec);
        if (r.opcode == OPC_SET_BOOT || !boot_set) begin
            boot_mark = res.epoch;
            boot_set  = 1'b1;
        end
        res.uptime = res.epoch - boot_mark;
        return res;
    endfunction

    task automatic push_reading(bit op, bit [7:0] s, bit [7:0] m, bit [7:0] h,
                                bit [7:0] d, bit [7:0] mo, bit [7:0] y, bit drain);
        clock_reading_t r;
        r.drain_first = drain;
        r.opcode      = op;
        r.sec         = s;
        r.min         = m;
        r.hr          = h;
        r.day         = d;
        r.mon         = mo;
        r.yr          = y;
        readings_q.push_back(r);
    endtask

    // Half are plausible clock readings, the rest raw byte noise
    task automatic push_random_reading(bit drain);
        bit op;
        op = ($urandom_range(99) < 15) ? OPC_SET_BOOT : OPC_QUERY;
        if ($urandom_range(1) == 1) begin
            push_reading(op, to_bcd($urandom_range(59)), to_bcd($urandom_range(59)),
                         to_bcd($urandom_range(23)), to_bcd($urandom_range(31, 1)),
                         to_bcd($urandom_range(12, 1)), to_bcd($urandom_range(99)),
                         drain);
        end else begin
            push_reading(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)), drain);
        end
    endtask

    // Input driver: hold a stalled beat, otherwise offer the next reading
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (readings_q.size() > 0 && $urandom_range(99) >= send_idle_pct
                    && (!readings_q[0].drain_first || expected_q.size() == 0)) begin
                i_opcode      <= readings_q[0].opcode;
                i_seconds_bcd <= readings_q[0].sec;
                i_minutes_bcd <= readings_q[0].min;
                i_hours_bcd   <= readings_q[0].hr;
                i_day_bcd     <= readings_q[0].day;
                i_month_bcd   <= readings_q[0].mon;
                i_year_bcd    <= readings_q[0].yr;
                i_in_valid    <= 1'b1;
                void'(readings_q.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: predict on each input beat, check each output beat, watch for hangs
    always @(posedge i_clk) begin
        bit             in_beat;
        bit             out_beat;
        clock_reading_t r;
        uptime_result_t exp_res;
        in_beat  = i_rst_n && i_in_valid && !o_in_stall;
        out_beat = i_rst_n && o_out_valid && !i_out_stall;
        in_took <= in_beat;
        if (out_beat) begin
            if (expected_q.size() == 0) begin
                $error("result beat with no reading outstanding: epoch %0d uptime %0d",
                       o_epoch_seconds, o_uptime_seconds);
                fail_count++;
            end else begin
                exp_res = expected_q.pop_front();
                if (o_epoch_seconds !== exp_res.epoch) begin
                    $error("epoch_seconds mismatch: expected %0d, actual %0d",
                           exp_res.epoch, o_epoch_seconds);
                    fail_count++;
                end
                if (o_uptime_seconds !== exp_res.uptime) begin
                    $error("uptime_seconds mismatch: expected %0d, actual %0d",
                           exp_res.uptime, o_uptime_seconds);
                    fail_count++;
                end
            end
        end
        if (in_beat) begin
            r.drain_first = 1'b0;
            r.opcode      = i_opcode;
            r.sec         = i_seconds_bcd;
            r.min         = i_minutes_bcd;
            r.hr          = i_hours_bcd;
            r.day         = i_day_bcd;
            r.mon         = i_month_bcd;
            r.yr          = i_year_bcd;
            expected_q.push_back(predict_uptime(r));
        end
        if (!i_rst_n || in_beat || out_beat) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int n;
        boot_mark      = '0;
        boot_set       = 1'b0;
        fail_count     = 0;
        quiet_cycles   = 0;
        in_took        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // First query captures boot, so its uptime is zero
        push_reading(OPC_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        push_reading(OPC_QUERY, 8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h24, 1'b0);
        push_reading(OPC_SET_BOOT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_reading(OPC_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        push_reading(OPC_QUERY, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 1'b0);
        push_reading(OPC_QUERY, 8'h30, 8'h15, 8'h12, 8'h28, 8'h02, 8'h00, 1'b0);
        push_reading(OPC_QUERY, 8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 1'b0);
        push_reading(OPC_QUERY, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 1'b0);
        push_reading(OPC_QUERY, 8'h00, 8'h00, 8'h00, 8'h15, 8'h13, 8'h50, 1'b0);
        // Wait for all outstanding results before re-arming boot
        push_reading(OPC_SET_BOOT, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 1'b1);
        push_reading(OPC_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h06, 1'b0);
        push_reading(OPC_QUERY, 8'hAA, 8'h0F, 8'hF0, 8'hA5, 8'h5A, 8'hC3, 1'b0);
        push_reading(OPC_QUERY, 8'h0F, 8'hF0, 8'h0F, 8'hF0, 8'h0F, 8'hF0, 1'b0);
        push_reading(OPC_QUERY, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hFF, 1'b0);
        push_reading(OPC_SET_BOOT, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 1'b0);
        push_reading(OPC_QUERY, 8'h07, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38, 1'b0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                push_random_reading(n == RANDOM_PER_PHASE / 2);
            end
            while (readings_q.size() != 0) @(negedge i_clk);
        end

        // Drain the pipe, then allow for any late stray beat
        while (i_in_valid || expected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
